// ----- hw/rtl/nhrt_pkg.sv -----
// Shared types, codes and defaults for the next-hop route table.
`default_nettype none
package nhrt_pkg;

    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int LIFETIME_BITS_DEF = 16;
    localparam int COUNT_W           = 9;

    localparam logic [7:0] WALK_LIMIT_RST = 8'd16;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_WALK_LIM  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  dest_id;
        logic [7:0]  next_hop;
        logic [7:0]  hop_count;
        logic [15:0] lifetime;
    } nhrt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_dest;
        logic [7:0]  entry_next;
        logic [7:0]  entry_hops;
        logic [15:0] entry_lifetime;
        logic [8:0]  valid_count;
    } nhrt_out_t;

    typedef struct packed {
        logic       set;
        logic       clr;
        logic       clear_all;
        logic [7:0] idx;
    } slot_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_DONE
    } nhrt_state_t;

    function automatic logic id_in_range(input logic [7:0] id, input int depth);
        return int'(id) < depth;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/next_hop_route_table.sv -----
// Top level of the next-hop route table: sequencer, entry store and slot valid bits.
//
//  Channel  | Signals                           | Direction
//  ---------+-----------------------------------+----------
//  in       | in_valid, in_stall, in_data       | request in
//  out      | out_valid, out_stall, out_data    | result out
//  cfg      | cfg_write, cfg_data (walk limit)  | write only
//
// Add, remove, clear, unused codes and a find or lookup whose first slot is not valid
// go from dispatch straight to done; a find that hits also passes through the read state.
// Route lookup stays in the read state for each entry it reads: the entry store
// has one read port and each slot visited costs one registered read.
// Reset clears all valid bits, the count and the walk limit (to 16) at once.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module next_hop_route_table #(
    parameter int TABLE_DEPTH   = nhrt_pkg::TABLE_DEPTH_DEF,
    parameter int LIFETIME_BITS = nhrt_pkg::LIFETIME_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire nhrt_pkg::nhrt_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output nhrt_pkg::nhrt_out_t      out_data,
    input  wire logic                cfg_write,
    input  wire logic [7:0]          cfg_data
);
    import nhrt_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 16 + LIFETIME_BITS;

    nhrt_state_t state_reg, state_next;
    nhrt_in_t    in_reg, in_next;
    nhrt_out_t   res_reg, res_next;
    nhrt_out_t   out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  steps_reg, steps_next;
    logic [7:0]  walk_limit_reg;

    logic                     ram_we, ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
    logic [7:0]               rd_next, rd_hops;
    logic [LIFETIME_BITS-1:0] rd_life;

    slot_cmd_t          slot_cmd;
    logic [7:0]         qry_idx;
    logic               qry_hit;
    logic [COUNT_W-1:0] slot_count;

    assign ram_wdata = {in_reg.next_hop, in_reg.hop_count, LIFETIME_BITS'(in_reg.lifetime)};
    assign {rd_next, rd_hops, rd_life} = ram_rdata;

    nhrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_reg.dest_id[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nhrt_slots #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (slot_cmd),
        .qry_idx (qry_idx),
        .qry_hit (qry_hit),
        .count   (slot_count)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = in_reg.dest_id[IDX_W-1:0];
        qry_idx        = in_reg.dest_id;
        slot_cmd       = '0;
        slot_cmd.idx   = in_reg.dest_id;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (in_reg.opcode) inside
                    OP_ADD:
                    begin
                        ram_we       = id_in_range(in_reg.dest_id, TABLE_DEPTH);
                        slot_cmd.set = 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        slot_cmd.clr = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        slot_cmd.clear_all = 1'b1;
                    end
                    OP_FIND, OP_LOOKUP:
                    begin
                        if (qry_hit)
                        begin
                            ram_re     = 1'b1;
                            cur_next   = in_reg.dest_id;
                            steps_next = '0;
                            state_next = S_READ;
                        end
                        else
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ:
            begin
                qry_idx    = rd_next;
                state_next = S_DONE;
                res_next   = '0;
                if (in_reg.opcode == OP_FIND || rd_next == cur_reg)
                begin
                    res_next.status         = ST_OK;
                    res_next.entry_dest     = cur_reg;
                    res_next.entry_next     = rd_next;
                    res_next.entry_hops     = rd_hops;
                    res_next.entry_lifetime = 16'(rd_life);
                end
                else if (steps_reg >= walk_limit_reg)
                begin
                    res_next.status = ST_WALK_LIM;
                end
                else if (!qry_hit)
                begin
                    res_next.status = ST_NOT_FOUND;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = rd_next[IDX_W-1:0];
                    cur_next   = rd_next;
                    steps_next = steps_reg + 8'd1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = res_reg;
                    out_data_next.valid_count = slot_count;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            walk_limit_reg <= WALK_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                walk_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DISPATCH)
        else $error("accepted request did not reach dispatch");

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> steps_reg <= walk_limit_reg)
        else $error("walk went past the walk limit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(slot_count) <= TABLE_DEPTH)
        else $error("valid count exceeds table depth");

    a_fail_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.entry_dest == 8'd0 && out_data.entry_next == 8'd0 &&
            out_data.entry_hops == 8'd0 && out_data.entry_lifetime == 16'd0)
        else $error("failed request returned entry data");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/nhrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nhrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/nhrt_slots.sv -----
// Per-slot valid bits and the count of valid slots.
`default_nettype none
module nhrt_slots #(
    parameter int TABLE_DEPTH = nhrt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire nhrt_pkg::slot_cmd_t            cmd,
    input  wire logic [7:0]                     qry_idx,
    output logic                                qry_hit,
    output logic [nhrt_pkg::COUNT_W-1:0]        count
);
    import nhrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       cmd_sel, qry_sel;
    logic                   cmd_in_range, qry_in_range;

    assign cmd_sel      = cmd.idx[IDX_W-1:0];
    assign qry_sel      = qry_idx[IDX_W-1:0];
    assign cmd_in_range = id_in_range(cmd.idx, TABLE_DEPTH);
    assign qry_in_range = id_in_range(qry_idx, TABLE_DEPTH);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.clear_all)
        begin
            valid_next = '0;
            count_next = '0;
        end
        else if (cmd.set && cmd_in_range && !valid_reg[cmd_sel])
        begin
            valid_next[cmd_sel] = 1'b1;
            count_next          = count_reg + CNT_W'(1);
        end
        else if (cmd.clr && cmd_in_range && valid_reg[cmd_sel])
        begin
            valid_next[cmd_sel] = 1'b0;
            count_next          = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign qry_hit = qry_in_range && valid_reg[qry_sel];
    assign count   = COUNT_W'(count_reg);

endmodule
`default_nettype wire
